### rtl/wav_pcm8_header_parse_and_convert_macros.svh
// assertion macros for the wav pcm8 header parser
`ifndef WAV_PCM8_HEADER_PARSE_AND_CONVERT_MACROS_SVH
`define WAV_PCM8_HEADER_PARSE_AND_CONVERT_MACROS_SVH
`ifndef SYNTHESIS
`define WPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wpc assertion failed");
`define WPC_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("wpc forbidden condition seen");
`else
`define WPC_ASSERT(lbl, clk, rst_n, prop)
`define WPC_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### rtl/wpc_pkg.sv
// shared types, constants and tables of the wav pcm8 header parser
`default_nettype none
package wpc_pkg;

    localparam int HEADER_LIMIT = 300;
    localparam int IDX_W        = $clog2(HEADER_LIMIT);
    localparam int LEN_W        = 24;
    localparam int ACT_Q_DEPTH  = 16;
    localparam int CMD_LEN      = 9;
    localparam int STEP_W       = $clog2(CMD_LEN);

    localparam logic [IDX_W-1:0] IDX_SIZE_LO   = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_SIZE_END  = IDX_W'(8);
    localparam logic [IDX_W-1:0] IDX_TAG_MIN   = IDX_W'(7);
    localparam logic [IDX_W-1:0] IDX_FIXED_END = IDX_W'(24);
    localparam logic [IDX_W-1:0] IDX_BPS_LO    = IDX_W'(34);
    localparam logic [IDX_W-1:0] IDX_BPS_HI    = IDX_W'(35);
    localparam logic [IDX_W-1:0] IDX_LAST      = IDX_W'(HEADER_LIMIT - 1);

    localparam logic [31:0] DATA_TAG     = 32'h64617461;
    localparam logic [7:0]  BPS_LO_OK    = 8'h08;
    localparam logic [7:0]  BPS_HI_OK    = 8'h00;
    localparam logic [7:0]  SAMPLE_FLIP  = 8'h80;
    localparam logic [7:0]  CMD_OPCODE   = 8'd23;
    localparam logic [7:0]  CMD_UPLOAD   = 8'd133;
    localparam logic [7:0]  CMD_SUBLEN   = 8'd5;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CMD_LEN - 1);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_SAMPLES = 2'd1,
        PH_SKIP    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ACT_SAMPLE    = 2'd0,
        ACT_CMD       = 2'd1,
        ACT_ERR_HDR   = 2'd2,
        ACT_ERR_WIDTH = 2'd3
    } t_act_kind;

    typedef enum logic [1:0] {
        KIND_CMD    = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_ERROR  = 2'd2
    } t_out_kind;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_HEADER = 2'd1,
        ERR_WIDTH  = 2'd2
    } t_err_code;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        t_out_kind  out_kind;
        t_err_code  error_code;
        logic       last_of_run;
    } t_result;

    // one unit of work handed from the parser to the emitter
    typedef struct packed {
        t_act_kind        kind;
        logic [LEN_W-1:0] value;
    } t_action;

    // expected header bytes at positions 0..23, size field is not checked
    function automatic logic [7:0] fixed_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'h52;
            5'd1:    b = 8'h49;
            5'd2:    b = 8'h46;
            5'd3:    b = 8'h46;
            5'd8:    b = 8'h57;
            5'd9:    b = 8'h41;
            5'd10:   b = 8'h56;
            5'd11:   b = 8'h45;
            5'd12:   b = 8'h66;
            5'd13:   b = 8'h6d;
            5'd14:   b = 8'h74;
            5'd15:   b = 8'h20;
            5'd16:   b = 8'h10;
            5'd20:   b = 8'h01;
            5'd22:   b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

### rtl/wpc_front.sv
// header parser: checks fixed bytes, finds the data tag and classifies each byte
`default_nettype none
`include "wav_pcm8_header_parse_and_convert_macros.svh"
module wpc_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire wpc_pkg::t_item  i_item,
    output logic                 o_act_valid,
    output wpc_pkg::t_action     o_act
);
    import wpc_pkg::*;

    t_phase           r_phase, n_phase;
    logic [IDX_W-1:0] r_byte_index, n_byte_index;
    logic             r_hdr_bad, n_hdr_bad;
    logic             r_width_bad, n_width_bad;
    logic [55:0]      r_recent, n_recent;
    logic [LEN_W-1:0] r_samples_left, n_samples_left;

    logic [7:0]       b;
    logic [63:0]      win;
    logic             fixed_bad;
    logic             bps_bad;
    logic             hdr_bad;
    logic             width_bad;
    logic             tag_hit;
    logic [LEN_W-1:0] len;

    always_comb begin
        b   = i_item.file_byte;
        win = {r_recent, b};
        fixed_bad = (r_byte_index < IDX_FIXED_END)
                 && !((r_byte_index >= IDX_SIZE_LO) && (r_byte_index < IDX_SIZE_END))
                 && (b != fixed_byte(r_byte_index[4:0]));
        bps_bad = ((r_byte_index == IDX_BPS_LO) && (b != BPS_LO_OK))
               || ((r_byte_index == IDX_BPS_HI) && (b != BPS_HI_OK));
        hdr_bad   = r_hdr_bad | fixed_bad;
        width_bad = r_width_bad | bps_bad;
        tag_hit   = (r_byte_index >= IDX_TAG_MIN) && (win[63:32] == DATA_TAG);
        // little-endian length, fourth byte dropped
        len = {win[15:8], win[23:16], win[31:24]};

        n_phase        = r_phase;
        n_byte_index   = r_byte_index;
        n_hdr_bad      = r_hdr_bad;
        n_width_bad    = r_width_bad;
        n_recent       = r_recent;
        n_samples_left = r_samples_left;
        o_act_valid    = 1'b0;
        o_act.kind     = ACT_SAMPLE;
        o_act.value    = '0;

        if (i_accept) begin
            case (r_phase)
                PH_HEADER: begin
                    n_hdr_bad   = hdr_bad;
                    n_width_bad = width_bad;
                    n_recent    = win[55:0];
                    if (tag_hit) begin
                        o_act_valid = 1'b1;
                        n_phase     = PH_SKIP;
                        if (hdr_bad || (r_byte_index < IDX_BPS_HI)) begin
                            o_act.kind = ACT_ERR_HDR;
                        end else if (width_bad) begin
                            o_act.kind = ACT_ERR_WIDTH;
                        end else begin
                            o_act.kind     = ACT_CMD;
                            o_act.value    = len;
                            n_samples_left = len;
                            if (len != '0) begin
                                n_phase = PH_SAMPLES;
                            end
                        end
                    end else if (i_item.end_of_file || (r_byte_index == IDX_LAST)) begin
                        o_act_valid = 1'b1;
                        o_act.kind  = ACT_ERR_HDR;
                        n_phase     = PH_SKIP;
                    end else begin
                        n_byte_index = r_byte_index + IDX_W'(1);
                    end
                end
                PH_SAMPLES: begin
                    o_act_valid    = 1'b1;
                    o_act.kind     = ACT_SAMPLE;
                    o_act.value    = {{(LEN_W - 8){1'b0}}, b ^ SAMPLE_FLIP};
                    n_samples_left = r_samples_left - LEN_W'(1);
                    if (n_samples_left == '0) begin
                        n_phase = PH_SKIP;
                    end
                end
                default: begin
                end
            endcase
            // a new file starts after the last byte
            if (i_item.end_of_file) begin
                n_phase        = PH_HEADER;
                n_byte_index   = '0;
                n_hdr_bad      = 1'b0;
                n_width_bad    = 1'b0;
                n_recent       = '0;
                n_samples_left = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_byte_index   <= '0;
            r_hdr_bad      <= 1'b0;
            r_width_bad    <= 1'b0;
            r_recent       <= '0;
            r_samples_left <= '0;
        end else begin
            r_phase        <= n_phase;
            r_byte_index   <= n_byte_index;
            r_hdr_bad      <= n_hdr_bad;
            r_width_bad    <= n_width_bad;
            r_recent       <= n_recent;
            r_samples_left <= n_samples_left;
        end
    end

    `WPC_NEVER(a_samples_nonzero, i_clk, i_rst_n, (r_phase == PH_SAMPLES) && (r_samples_left == '0))
    `WPC_ASSERT(a_eof_restart, i_clk, i_rst_n, (i_accept && i_item.end_of_file) |=> ((r_phase == PH_HEADER) && (r_byte_index == '0)))

endmodule
`default_nettype wire

### rtl/wpc_queue.sv
// action queue between parser and emitter
`default_nettype none
`include "wav_pcm8_header_parse_and_convert_macros.svh"
module wpc_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire wpc_pkg::t_action  i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output wpc_pkg::t_action       o_head
);
    import wpc_pkg::*;

    localparam int PTR_W = $clog2(ACT_Q_DEPTH);
    localparam int CNT_W = $clog2(ACT_Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ACT_Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ACT_Q_DEPTH);

    t_action          r_mem [ACT_Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    always_comb begin
        o_full   = (r_count == CNT_FULL);
        o_empty  = (r_count == '0);
        o_head   = r_mem[r_rd_ptr];
        do_push  = i_push && !o_full;
        do_pop   = i_pop && !o_empty;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

### rtl/wpc_back.sv
// emitter: expands each action into result bytes behind one output register
`default_nettype none
`include "wav_pcm8_header_parse_and_convert_macros.svh"
module wpc_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [7:0]        i_sample_slot,
    input  wire logic              i_q_empty,
    input  wire wpc_pkg::t_action  i_head,
    output logic                   o_q_pop,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output wpc_pkg::t_result       o_result
);
    import wpc_pkg::*;

    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;
    logic              can_load;
    logic              head_cmd;
    logic [7:0]        cmd_bytes [CMD_LEN];

    always_comb begin
        cmd_bytes[0] = CMD_OPCODE;
        cmd_bytes[1] = 8'h00;
        cmd_bytes[2] = CMD_UPLOAD;
        cmd_bytes[3] = 8'h00 - i_sample_slot;
        cmd_bytes[4] = CMD_SUBLEN;
        cmd_bytes[5] = 8'h00;
        cmd_bytes[6] = i_head.value[7:0];
        cmd_bytes[7] = i_head.value[15:8];
        cmd_bytes[8] = i_head.value[23:16];
    end

    always_comb begin
        // the output register reloads in the same cycle it is popped
        can_load    = !r_out_valid || i_pop;
        head_cmd    = (i_head.kind == ACT_CMD);
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        o_q_pop     = 1'b0;

        if (can_load && !i_q_empty) begin
            n_out_valid          = 1'b1;
            n_out.out_byte       = 8'h00;
            n_out.out_kind       = KIND_ERROR;
            n_out.error_code     = ERR_NONE;
            n_out.last_of_run    = 1'b1;
            case (i_head.kind)
                ACT_SAMPLE: begin
                    n_out.out_byte = i_head.value[7:0];
                    n_out.out_kind = KIND_SAMPLE;
                end
                ACT_CMD: begin
                    n_out.out_byte    = cmd_bytes[r_step];
                    n_out.out_kind    = KIND_CMD;
                    n_out.last_of_run = (r_step == STEP_LAST);
                end
                ACT_ERR_HDR: begin
                    n_out.error_code = ERR_HEADER;
                end
                ACT_ERR_WIDTH: begin
                    n_out.error_code = ERR_WIDTH;
                end
                default: begin
                end
            endcase
            if (!head_cmd || (r_step == STEP_LAST)) begin
                o_q_pop = 1'b1;
                n_step  = '0;
            end else begin
                n_step = r_step + STEP_W'(1);
            end
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    `WPC_ASSERT(a_step_in_cmd, i_clk, i_rst_n, (r_step != '0) |-> (!i_q_empty && (i_head.kind == ACT_CMD)))
    `WPC_ASSERT(a_out_held, i_clk, i_rst_n, (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out)))

endmodule
`default_nettype wire

### rtl/wav_pcm8_header_parse_and_convert.sv
// Throughput: one file byte accepted per cycle unless the action queue is full; a sample byte
// gives one result. A good header yields a 9-result command burst from its last length byte,
// emitted at one result per cycle while pop is high by the single output register, while the
// 16-entry action queue takes input. Actions are queued, then loaded into the output register.
// Reset: synchronous, active low; clears parser state, queue, output valid and sample slot.
`default_nettype none
module wav_pcm8_header_parse_and_convert (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire wpc_pkg::t_item    i_item,
    output logic                   empty,
    input  wire logic              pop,
    output wpc_pkg::t_result       o_result,
    input  wire logic              i_cfg_we,
    input  wire logic [7:0]        i_cfg_wdata
);
    import wpc_pkg::*;

    logic [7:0] r_sample_slot;
    logic       accept;
    logic       act_valid;
    t_action    act;
    logic       q_empty;
    logic       q_pop;
    t_action    q_head;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_slot <= 8'h00;
        end else if (i_cfg_we) begin
            r_sample_slot <= i_cfg_wdata;
        end
    end

    wpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_act_valid (act_valid),
        .o_act       (act)
    );

    wpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (act_valid),
        .i_data  (act),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    wpc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sample_slot (r_sample_slot),
        .i_q_empty     (q_empty),
        .i_head        (q_head),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_result      (o_result)
    );

endmodule
`default_nettype wire

### bench/tb_wav_pcm8_header_parse_and_convert.sv
// testbench for the 8-bit mono wav header parser and sample converter
`timescale 1ns / 1ps

module tb_wav_pcm8_header_parse_and_convert;
    import wpc_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 480;
    localparam int MAX_PRINTS   = 40;

    // checked header bytes 0..23, the riff size field at 4..7 is never compared
    localparam logic [0:23][7:0] HDR_FIXED = {"RIFF", 32'h0, "WAVE", "fmt ",
                                              64'h1000_0000_0100_0100};
    localparam logic [31:0] TAG_DATA = "data";

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       push        = 1'b0;
    logic       pop         = 1'b0;
    t_item      i_item      = '0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = 8'h00;
    logic       full;
    logic       empty;
    t_result    o_result;

    // parser state of the prediction
    t_phase      parse_phase;
    int          hdr_index;
    logic        hdr_bad;
    logic        width_bad;
    logic [63:0] last8;
    logic [23:0] samples_due;
    logic [7:0]  slot_cfg;

    t_result     pending_results[$];
    logic [7:0]  wav_bytes[$];

    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int useful_items  = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    wav_pcm8_header_parse_and_convert u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    task automatic report_mismatch(input string field, input logic [7:0] got_v,
                                   input logic [7:0] want_v);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch on result %0d: %s got %0d expected %0d",
                     results_seen, field, got_v, want_v);
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, out_byte", o_result.out_byte, 8'h00);
            end else begin
                want = pending_results.pop_front();
                if (o_result.out_byte !== want.out_byte)
                    report_mismatch("out_byte", o_result.out_byte, want.out_byte);
                if (o_result.out_kind !== want.out_kind)
                    report_mismatch("out_kind", 8'(o_result.out_kind), 8'(want.out_kind));
                if (o_result.error_code !== want.error_code)
                    report_mismatch("error_code", 8'(o_result.error_code),
                                    8'(want.error_code));
                if (o_result.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", 8'(o_result.last_of_run),
                                    8'(want.last_of_run));
            end
            results_seen++;
        end
    end

    function automatic t_result mk_result(input logic [7:0] b, input t_out_kind kind,
                                          input t_err_code err);
        t_result r;
        r.out_byte    = b;
        r.out_kind    = kind;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    task automatic restart_file();
        parse_phase = PH_HEADER;
        hdr_index   = 0;
        hdr_bad     = 1'b0;
        width_bad   = 1'b0;
        last8       = '0;
        samples_due = '0;
    endtask

    // expected results of one accepted file byte
    task automatic parse_wav_byte(input t_item it);
        logic [7:0]  b;
        logic [23:0] len;
        t_result     r;
        t_result     burst[$];
        b = it.file_byte;
        if (parse_phase != PH_SKIP)
            useful_items++;
        if (parse_phase == PH_HEADER) begin
            if (hdr_index < 24) begin
                if (!(hdr_index >= 4 && hdr_index < 8) && b != HDR_FIXED[hdr_index])
                    hdr_bad = 1'b1;
            end else if (hdr_index == 34) begin
                if (b != 8'h08)
                    width_bad = 1'b1;
            end else if (hdr_index == 35) begin
                if (b != 8'h00)
                    width_bad = 1'b1;
            end
            last8 = {last8[55:0], b};
            if (hdr_index >= 7 && last8[63:32] == TAG_DATA) begin
                len = {last8[15:8], last8[23:16], last8[31:24]};
                if (hdr_bad || hdr_index < 35) begin
                    burst.push_back(mk_result(8'h00, KIND_ERROR, ERR_HEADER));
                    parse_phase = PH_SKIP;
                end else if (width_bad) begin
                    burst.push_back(mk_result(8'h00, KIND_ERROR, ERR_WIDTH));
                    parse_phase = PH_SKIP;
                end else begin
                    burst.push_back(mk_result(8'd23, KIND_CMD, ERR_NONE));
                    burst.push_back(mk_result(8'd0, KIND_CMD, ERR_NONE));
                    burst.push_back(mk_result(8'd133, KIND_CMD, ERR_NONE));
                    burst.push_back(mk_result(~slot_cfg + 8'd1, KIND_CMD, ERR_NONE));
                    burst.push_back(mk_result(8'd5, KIND_CMD, ERR_NONE));
                    burst.push_back(mk_result(8'd0, KIND_CMD, ERR_NONE));
                    burst.push_back(mk_result(len[7:0], KIND_CMD, ERR_NONE));
                    burst.push_back(mk_result(len[15:8], KIND_CMD, ERR_NONE));
                    burst.push_back(mk_result(len[23:16], KIND_CMD, ERR_NONE));
                    samples_due = len;
                    parse_phase = (len != 0) ? PH_SAMPLES : PH_SKIP;
                end
            end else if (it.end_of_file || hdr_index + 1 >= HEADER_LIMIT) begin
                burst.push_back(mk_result(8'h00, KIND_ERROR, ERR_HEADER));
                parse_phase = PH_SKIP;
            end else begin
                hdr_index++;
            end
        end else if (parse_phase == PH_SAMPLES) begin
            burst.push_back(mk_result(b - 8'd128, KIND_SAMPLE, ERR_NONE));
            samples_due = samples_due - 24'd1;
            if (samples_due == 0)
                parse_phase = PH_SKIP;
        end
        foreach (burst[k]) begin
            r = burst[k];
            r.last_of_run = (k == burst.size() - 1);
            pending_results.push_back(r);
        end
        if (it.end_of_file)
            restart_file();
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 55; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 55; end
            default: begin send_idle_pct = 35; pop_stall_pct = 35; end
        endcase
    endtask

    // called and returns at a falling edge; push stays high for a following transfer
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int    gap;
        t_item it;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        it.file_byte   = b;
        it.end_of_file = eof;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        parse_wav_byte(it);
        @(negedge i_clk);
    endtask

    task automatic send_file();
        foreach (wav_bytes[k])
            send_byte(wav_bytes[k], k == wav_bytes.size() - 1);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_slot(input logic [7:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        slot_cfg = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // tail_n: how many of the bytes 24..35 are present, bits per sample at 34..35
    task automatic build_header(input int tail_n, input logic [15:0] bps, input int pad,
                                input logic [31:0] len);
        wav_bytes.delete();
        for (int k = 0; k < 24; k++)
            wav_bytes.push_back((k >= 4 && k < 8) ? 8'($urandom_range(255)) : HDR_FIXED[k]);
        for (int k = 0; k < tail_n; k++)
            wav_bytes.push_back(k == 10 ? bps[7:0] :
                                k == 11 ? bps[15:8] : 8'($urandom_range(255)));
        for (int k = 0; k < pad; k++)
            wav_bytes.push_back(8'($urandom_range(255)));
        for (int k = 0; k < 4; k++)
            wav_bytes.push_back(TAG_DATA[31 - 8 * k -: 8]);
        for (int k = 0; k < 4; k++)
            wav_bytes.push_back(len[8 * k +: 8]);
    endtask

    task automatic add_samples(input int n);
        repeat (n) wav_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic corrupt_fixed_byte();
        int         k;
        logic [7:0] flip;
        k    = $urandom_range(19);
        k    = (k < 4) ? k : k + 4;
        flip = 8'($urandom_range(255, 1));
        wav_bytes[k] = wav_bytes[k] ^ flip;
    endtask

    task automatic test_good_files();
        set_idling(0);
        build_header(12, 16'h0008, 0, 32'd4);
        wav_bytes.push_back(8'h00);
        wav_bytes.push_back(8'hFF);
        wav_bytes.push_back(8'h7F);
        wav_bytes.push_back(8'h80);
        send_file();
        wait_idle();
        write_slot(8'hFF);
        set_idling(1);
        build_header(12, 16'h0008, 6, 32'd2);
        add_samples(2);
        send_file();
        wait_idle();
        write_slot(8'h80);
        set_idling(2);
        build_header(12, 16'h0008, 0, 32'd1);
        add_samples(1);
        send_file();
        wait_idle();
        write_slot(8'h01);
    endtask

    task automatic test_zero_length();
        set_idling(3);
        build_header(12, 16'h0008, 0, 32'd0);
        add_samples(3);
        send_file();
    endtask

    task automatic test_length_and_short_file();
        set_idling(1);
        // top length byte is dropped, bytes past the length are dropped too
        build_header(12, 16'h0008, 0, 32'hA500_0003);
        add_samples(5);
        send_file();
        set_idling(2);
        build_header(12, 16'h0008, 0, 32'h00FF_FFFF);
        add_samples(5);
        send_file();
        build_header(12, 16'h0008, 0, 32'd2);
        add_samples(2);
        send_file();
    endtask

    task automatic test_header_errors();
        set_idling(3);
        build_header(12, 16'h0008, 0, 32'd2);
        corrupt_fixed_byte();
        add_samples(2);
        send_file();
        build_header(12, 16'h0010, 0, 32'd2);
        add_samples(2);
        send_file();
        build_header(12, 16'h0108, 0, 32'd2);
        add_samples(1);
        send_file();
        // invalid header wins over a wrong width
        build_header(12, 16'h0018, 0, 32'd2);
        corrupt_fixed_byte();
        send_file();
    endtask

    task automatic test_missing_header_bytes();
        set_idling(0);
        build_header(0, 16'h0008, 0, 32'd2);
        add_samples(2);
        send_file();
        build_header(3, 16'h0008, 0, 32'd1);
        send_file();
        build_header(8, 16'h0008, 0, 32'd1);
        add_samples(1);
        send_file();
    endtask

    task automatic test_early_end_of_file();
        set_idling(1);
        send_byte("R", 1'b1);
        build_header(12, 16'h0008, 0, 32'd3);
        while (wav_bytes.size() > 20)
            void'(wav_bytes.pop_back());
        send_file();
        build_header(12, 16'h0008, 0, 32'd3);
        while (wav_bytes.size() > 42)
            void'(wav_bytes.pop_back());
        send_file();
    endtask

    task automatic test_tag_at_limit();
        set_idling(3);
        // last length byte lands on the final allowed header position
        build_header(12, 16'h0008, HEADER_LIMIT - 44, 32'd2);
        add_samples(2);
        send_file();
        build_header(12, 16'h0008, HEADER_LIMIT - 43, 32'd2);
        add_samples(2);
        send_file();
    endtask

    task automatic test_random_files();
        int          files;
        int          kind;
        int          n;
        int          extra;
        int          start;
        logic [31:0] len;
        files = 0;
        start = useful_items;
        while (useful_items - start < RANDOM_ITEMS) begin
            set_idling(files % 4);
            if (files % 3 == 2) begin
                wait_idle();
                case ($urandom_range(3))
                    0: write_slot(8'h00);
                    1: write_slot(8'hFF);
                    default: write_slot(8'($urandom_range(255)));
                endcase
            end
            kind  = $urandom_range(99);
            n     = $urandom_range(16);
            extra = $urandom_range(3);
            len   = {8'($urandom_range(255)), 24'(n)};
            if (kind < 55) begin
                build_header(12, 16'h0008, $urandom_range(6), len);
                case ($urandom_range(2))
                    0: add_samples(n);
                    1: add_samples(n + extra + 1);
                    default: add_samples(n / 2);
                endcase
            end else if (kind < 65) begin
                build_header(12, 16'h0008, $urandom_range(6), len);
                corrupt_fixed_byte();
                add_samples(n);
            end else if (kind < 73) begin
                build_header(12, 16'($urandom_range(65535)), 0, len);
                add_samples(n);
            end else if (kind < 79) begin
                build_header($urandom_range(11), 16'h0008, 0, len);
                add_samples(n);
            end else if (kind < 87) begin
                build_header(12, 16'h0008, $urandom_range(6), len);
                n = $urandom_range(wav_bytes.size() - 1, 1);
                while (wav_bytes.size() > n)
                    void'(wav_bytes.pop_back());
            end else if (kind < 93) begin
                wav_bytes.delete();
                add_samples($urandom_range(30, 1));
            end else begin
                build_header(12, 16'h0008, 0, {8'($urandom_range(255)), 24'd0});
                add_samples(extra);
            end
            send_file();
            files++;
        end
    endtask

    initial begin
        slot_cfg = 8'h00;
        restart_file();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_good_files();
        test_zero_length();
        test_length_and_short_file();
        test_header_errors();
        test_missing_header_bytes();
        test_early_end_of_file();
        test_tag_at_limit();
        test_random_files();
        wait_idle();
        if (pending_results.size() != 0)
            report_mismatch("results never seen", 8'(pending_results.size()), 8'h00);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
